/* rtl/gcms_pkg.sv */
// ----------------------------------------------------------------------------
// gcms_pkg
// shared types and constants of the gradient color map sampler
// ----------------------------------------------------------------------------
package gcms_pkg;

  localparam int unsigned HUE_STEPS = 1536;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 43;

  localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;

  typedef struct packed {
    logic [10:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [15:0] pos;
  } stop_t;

  // word passed from front to back
  typedef struct packed {
    logic [15:0] p;
    logic [15:0] plo;
    logic [15:0] phi;
    logic [10:0] h0;
    logic [10:0] h1;
    logic [7:0]  s0;
    logic [7:0]  s1;
    logic [7:0]  v0;
    logic [7:0]  v1;
  } seg_t;

  function automatic logic [10:0] hue_wrap(input logic [10:0] h);
    logic [10:0] r;
    r = (h >= 11'(HUE_STEPS)) ? h - 11'(HUE_STEPS) : h;
    return r;
  endfunction

endpackage

/* rtl/gcms_front.sv */
// ----------------------------------------------------------------------------
// gcms_front
// snaps position to discrete levels (when levels >= 2) and selects the enclosing stop pair
// ----------------------------------------------------------------------------
module gcms_front
  import gcms_pkg::*;
#(
  parameter int unsigned MAX_STOPS = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [15:0]               pos_i,
  input  logic [15:0]               levels_i,
  input  logic [2:0]                count_i,
  input  stop_t [MAX_STOPS-1:0]     stops_i,
  output logic                      busy,
  input  logic                      q_full_i,
  output logic                      push_o,
  output seg_t                      seg_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SRCH = 5'b01000,
    S_PUSH = 5'b10000
  } fst_t;

  fst_t        st_r, st_nxt;
  logic [15:0] p_r, p_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic [2:0]  lo_r, lo_nxt;
  logic [2:0]  cnt;
  logic [15:0] idx;
  logic [15:0] nm1;

  always_comb begin
    cnt = count_i;
    if (cnt < 3'd2) cnt = 3'd2;
    if (32'(cnt) > MAX_STOPS) cnt = 3'(MAX_STOPS);
  end

  assign nm1 = levels_i - 16'd1;
  assign idx = (prod_r[31:15] >= {1'b0, levels_i}) ? nm1 : prod_r[30:15];

  always_comb begin
    st_nxt = st_r;
    p_nxt = p_r;
    prod_nxt = prod_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    bit_nxt = bit_r;
    lo_nxt = lo_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          p_nxt = pos_i;
          prod_nxt = 32'(pos_i) * 32'(levels_i);
          lo_nxt = '0;
          st_nxt = (levels_i >= 16'd2) ? S_MUL : S_SRCH;
        end
      end
      S_MUL: begin
        // dividend idx * 32768, restoring division over 31 bits
        rem_nxt = '0;
        quo_nxt = '0;
        prod_nxt = {1'b0, idx, 15'd0};
        bit_nxt = 5'd30;
        st_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = {rem_r[30:0], prod_r[bit_r]};
        if ({rem_r[30:0], prod_r[bit_r]} >= 32'(nm1)) begin
          rem_nxt = {rem_r[30:0], prod_r[bit_r]} - 32'(nm1);
          quo_nxt = {quo_r[14:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[14:0], 1'b0};
        end
        bit_nxt = bit_r - 5'd1;
        if (bit_r == 5'd0) st_nxt = S_SRCH;
        if (bit_r == 5'd0) p_nxt = quo_nxt;
      end
      S_SRCH: begin
        if (32'(lo_r) + 2 < 32'(cnt) && p_r > stops_i[lo_r + 3'd1].pos)
          lo_nxt = lo_r + 3'd1;
        else
          st_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!q_full_i) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    p_r <= p_nxt;
    prod_r <= prod_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
    lo_r <= lo_nxt;
  end

  assign busy = st_r != S_IDLE;
  assign push_o = (st_r == S_PUSH) && !q_full_i;

  always_comb begin
    seg_o.p   = p_r;
    seg_o.plo = stops_i[lo_r].pos;
    seg_o.phi = stops_i[lo_r + 3'd1].pos;
    seg_o.h0  = hue_wrap(stops_i[lo_r].hue);
    seg_o.h1  = hue_wrap(stops_i[lo_r + 3'd1].hue);
    seg_o.s0  = stops_i[lo_r].sat;
    seg_o.s1  = stops_i[lo_r + 3'd1].sat;
    seg_o.v0  = stops_i[lo_r].val;
    seg_o.v1  = stops_i[lo_r + 3'd1].val;
  end

endmodule

/* rtl/gcms_queue.sv */
// ----------------------------------------------------------------------------
// gcms_queue
// two-entry fifo between front and back
// ----------------------------------------------------------------------------
module gcms_queue
  import gcms_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  seg_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output seg_t data_o
);

  seg_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push_i) wp_r <= ~wp_r;
      if (pop_i) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_i) - 2'(pop_i);
    end
    if (push_i) mem_r[wp_r] <= data_i;
  end

  assign full_o = cnt_r == 2'd2;
  assign empty_o = cnt_r == 2'd0;
  assign data_o = mem_r[rp_r];

endmodule

/* rtl/gcms_back.sv */
// ----------------------------------------------------------------------------
// gcms_back
// local fraction by serial division, then channel interpolation
// ----------------------------------------------------------------------------
module gcms_back
  import gcms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        empty_i,
  input  seg_t        seg_i,
  output logic        pop_o,
  output logic        strobe_o,
  output logic [10:0] hue_o,
  output logic [7:0]  sat_o,
  output logic [7:0]  val_o
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_MIX  = 4'b0100,
    B_OUT  = 4'b1000
  } bst_t;

  bst_t        st_r, st_nxt;
  seg_t        seg_r;
  logic [16:0] f_r, f_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [31:0] num_r, num_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic [15:0] den;
  logic [17:0] shifted;
  logic [11:0] ha, hb;
  logic [10:0] hue_gap;
  logic [31:0] hmix, smix, vmix;
  logic [11:0] hsum;

  assign den = seg_r.phi - seg_r.plo;
  assign shifted = {rem_r, num_r[bit_r]};

  always_comb begin
    st_nxt = st_r;
    f_nxt = f_r;
    rem_nxt = rem_r;
    num_nxt = num_r;
    bit_nxt = bit_r;
    pop_o = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          st_nxt = B_DIV;
          bit_nxt = 5'd31;
          rem_nxt = '0;
          f_nxt = '0;
          num_nxt = {seg_i.p - seg_i.plo, 16'd0};
        end
      end
      B_DIV: begin
        if (seg_r.phi <= seg_r.plo || seg_r.p <= seg_r.plo) begin
          f_nxt = '0;
          st_nxt = B_MIX;
        end else if (seg_r.p >= seg_r.phi) begin
          f_nxt = 17'h10000;
          st_nxt = B_MIX;
        end else begin
          if (shifted >= 18'(den)) begin
            rem_nxt = 17'(shifted - 18'(den));
            f_nxt = {f_r[15:0], 1'b1};
          end else begin
            rem_nxt = shifted[16:0];
            f_nxt = {f_r[15:0], 1'b0};
          end
          bit_nxt = bit_r - 5'd1;
          if (bit_r == 5'd0) st_nxt = B_MIX;
        end
      end
      B_MIX: st_nxt = B_OUT;
      B_OUT: st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    ha = {1'b0, seg_r.h0};
    hb = {1'b0, seg_r.h1};
    hue_gap = (seg_r.h1 > seg_r.h0) ? seg_r.h1 - seg_r.h0 : seg_r.h0 - seg_r.h1;
    if (11'(HUE_STEPS) - hue_gap < hue_gap) begin
      if (seg_r.h0 < seg_r.h1) ha = ha + 12'(HUE_STEPS);
      else hb = hb + 12'(HUE_STEPS);
    end
  end

  // c0*65536 + (c1-c0)*f is never negative for f in 0..65536
  assign hmix = {4'd0, ha, 16'd0} + 32'($signed({1'b0, hb}) - $signed({1'b0, ha}))
                * 32'(f_r);
  assign smix = {8'd0, seg_r.s0, 16'd0}
                + 32'($signed({1'b0, seg_r.s1}) - $signed({1'b0, seg_r.s0})) * 32'(f_r);
  assign vmix = {8'd0, seg_r.v0, 16'd0}
                + 32'($signed({1'b0, seg_r.v1}) - $signed({1'b0, seg_r.v0})) * 32'(f_r);
  assign hsum = hmix[27:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    if (pop_o) seg_r <= seg_i;
    f_r <= f_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    bit_r <= bit_nxt;
    if (st_r == B_MIX) begin
      hue_o <= (hsum >= 12'(HUE_STEPS)) ? 11'(hsum - 12'(HUE_STEPS)) : hsum[10:0];
      sat_o <= smix[23:16];
      val_o <= vmix[23:16];
    end
  end

  assign strobe_o = st_r == B_OUT;

endmodule

/* rtl/gradient_color_map_sampler_unit.sv */
// ----------------------------------------------------------------------------
// gradient_color_map_sampler_unit
// maps a q1.15 position to an hsv color from up to six gradient stops
// ----------------------------------------------------------------------------
// Pulse start with in_position while busy is low; the color appears for one
// cycle with out_valid. The receiver cannot stall. The front holds busy
// after accepting a word while it searches the stops (one per step) and
// pushes to the queue, first running the serial snap divider with discrete
// levels, and longer while the two-entry queue is full. The back handles
// each word in order: pop, serial fraction divider, mix, output, skipping
// the divider steps when the fraction is plainly 0 or 1. The front can take
// a new word while the back still works on earlier ones, until the queue fills.
module gradient_color_map_sampler_unit
  import gcms_pkg::*;
#(
  parameter int unsigned MAX_STOPS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [15:0]           in_position,
  output logic                  out_valid,
  output logic [10:0]           out_hue,
  output logic [7:0]            out_saturation,
  output logic [7:0]            out_brightness,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0]           levels_r;
  logic [2:0]            count_r;
  stop_t [MAX_STOPS-1:0] stops_r;
  logic                  q_full, q_empty, push, pop;
  seg_t                  seg_f, seg_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= '0;
      count_r <= 3'd4;
      for (int k = 0; k < MAX_STOPS; k++) begin
        case (k)
          0: stops_r[k] <= stop_t'(43'd4294901760);
          1: stops_r[k] <= stop_t'(43'd2203318168125);
          2: stops_r[k] <= stop_t'(43'd4402341434491);
          3: stops_r[k] <= stop_t'(43'd6597069733888);
          default: stops_r[k] <= '0;
        endcase
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_LEVELS) levels_r <= cfg_data[15:0];
      else if (cfg_index == REG_COUNT) count_r <= cfg_data[2:0];
      else begin
        for (int k = 0; k < MAX_STOPS; k++)
          if (32'(cfg_index) == k + 2) stops_r[k] <= cfg_data;
      end
    end
  end

  gcms_front #(.MAX_STOPS(MAX_STOPS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .pos_i(in_position),
    .levels_i(levels_r), .count_i(count_r), .stops_i(stops_r), .busy(busy),
    .q_full_i(q_full), .push_o(push), .seg_o(seg_f)
  );

  gcms_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push_i(push), .data_i(seg_f), .full_o(q_full),
    .pop_i(pop), .empty_o(q_empty), .data_o(seg_q)
  );

  gcms_back u_back (
    .clk(clk), .rst_n(rst_n), .empty_i(q_empty), .seg_i(seg_q), .pop_o(pop),
    .strobe_o(out_valid), .hue_o(out_hue), .sat_o(out_saturation),
    .val_o(out_brightness)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full && !pop)) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_empty)) else $error("pop from empty queue");
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < 11'(HUE_STEPS)) else $error("hue out of range");

endmodule
